### src/bar_pkg.sv
`timescale 1ns / 1ps
// Package for the block-ack reorder buffer: payload structs, codes, FSM states
// and the command/status bundles between controller and datapath. No dependencies.
package bar_pkg;

    localparam int SEQ_W    = 12;
    localparam int HANDLE_W = 16;
    localparam int WSZ_W    = 6;
    localparam int CFG_W    = 12;

    localparam logic [SEQ_W-1:0] HALF_SPACE = 12'd2048;
    localparam logic [SEQ_W-1:0] SEQ_MASK   = 12'hFFF;

    localparam logic CFG_IDX_WINDOW = 1'b0;
    localparam logic CFG_IDX_START  = 1'b1;

    typedef enum logic [2:0] {
        ACT_FRAME  = 3'd0,
        ACT_AGING  = 3'd1,
        ACT_SCROLL = 3'd2,
        ACT_CLOSE  = 3'd3,
        ACT_OPEN   = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        DISP_NONE    = 3'd0,
        DISP_DELIVER = 3'd1,
        DISP_DUP     = 3'd2,
        DISP_OLD     = 3'd3,
        DISP_FLUSH   = 3'd4,
        DISP_NOSESS  = 3'd5
    } t_disp;

    typedef enum logic [1:0] {
        TCMD_NONE  = 2'd0,
        TCMD_START = 2'd1,
        TCMD_STOP  = 2'd2
    } t_tcmd;

    typedef struct packed {
        logic [2:0]          action;
        logic [SEQ_W-1:0]    seq;
        logic [HANDLE_W-1:0] handle;
        logic                flush_mode;
    } t_item;

    typedef struct packed {
        logic [HANDLE_W-1:0] out_handle;
        logic [SEQ_W-1:0]    out_seq;
        logic [2:0]          disposition;
        logic [1:0]          timer_cmd;
        logic                last;
    } t_result;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SLIDE,
        ST_MOD_PTR,
        ST_FRAME2,
        ST_MOD_SLOT,
        ST_DRAIN,
        ST_AGE,
        ST_CLOSE,
        ST_OPEN_INIT,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic  latch;
        logic  emit_in;
        logic  emit_nosess;
        logic  rel_ptr;
        logic  rel_sptr;
        t_disp disp;
        logic  advance;
        logic  set_ast;
        logic  set_restart;
        logic  ld_slide;
        logic  slide_sel;
        logic  ld_cnt_win;
        logic  dec_cnt;
        logic  set_exp_tgt;
        logic  mod_start;
        logic  mod_sel;
        logic  set_ptr_mod;
        logic  store;
        logic  scan_init;
        logic  scan_step;
        logic  clr_active;
        logic  open_init;
        logic  timer_wr;
        logic  timer_val;
        logic  cmd_wr;
        t_tcmd cmd_val;
        logic  finish;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] action;
        logic       flush;
        logic       active;
        logic       in_half;
        logic       beyond;
        logic       big;
        logic       cnt_zero;
        logic       cnt_one;
        logic       valid_ptr;
        logic       valid_sptr;
        logic       valid_mod;
        logic       mod_done;
        logic       seq_eq_exp;
        logic       same_open;
        logic       timer;
        logic       restart;
        logic       occ_nz;
        logic       ast;
    } t_dp_stat;

endpackage

### src/bar_mod.sv
`timescale 1ns / 1ps
// Bit-serial remainder unit: slot index = dividend mod window, one bit a cycle.
// Depends on bar_pkg.
module bar_mod #(
    parameter int WIN_W  = 6,
    parameter int SLOT_W = 5
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [bar_pkg::SEQ_W-1:0] i_dividend,
    input  logic [WIN_W-1:0]         i_divisor,
    output logic                     o_done,
    output logic [SLOT_W-1:0]        o_rem
);
    import bar_pkg::*;

    localparam int CntW = $clog2(SEQ_W);

    logic              r_busy;
    logic              r_done;
    logic [CntW-1:0]   r_cnt;
    logic [SEQ_W-1:0]  r_dvd;
    logic [WIN_W-1:0]  r_rem;
    logic [WIN_W:0]    w_trial;
    logic              w_ge;
    logic [WIN_W-1:0]  n_rem;

    always_comb begin
        w_trial = {r_rem, r_dvd[SEQ_W-1]};
        w_ge    = w_trial >= {1'b0, i_divisor};
        n_rem   = w_ge ? WIN_W'(w_trial - {1'b0, i_divisor}) : WIN_W'(w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CntW'(1);
                if (r_cnt == CntW'(SEQ_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[SEQ_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = SLOT_W'(r_rem);

endmodule

### src/bar_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the reorder buffer: walks the window one slot a cycle and
// drives the datapath by command bundle. Depends on bar_pkg.
module bar_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  bar_pkg::t_dp_stat i_stat,
    output bar_pkg::t_dp_cmd  o_cmd
);
    import bar_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) n_state = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                case (i_stat.action)
                    ACT_FRAME: begin
                        if (!i_stat.active) n_state = ST_FIN;
                        else if (!i_stat.in_half) n_state = ST_DRAIN;
                        else if (i_stat.beyond) n_state = ST_SLIDE;
                        else n_state = ST_FRAME2;
                    end
                    ACT_AGING: begin
                        n_state = (i_stat.active && i_stat.occ_nz) ? ST_AGE : ST_FIN;
                    end
                    ACT_SCROLL: begin
                        n_state = (i_stat.active && i_stat.in_half) ? ST_SLIDE : ST_FIN;
                    end
                    ACT_CLOSE: begin
                        n_state = i_stat.active ? ST_CLOSE : ST_FIN;
                    end
                    ACT_OPEN: begin
                        if (!i_stat.active) n_state = ST_OPEN_INIT;
                        else if (i_stat.same_open) n_state = ST_FIN;
                        else n_state = ST_CLOSE;
                    end
                    default: n_state = ST_FIN;
                endcase
            end
            ST_SLIDE: begin
                if (i_stat.cnt_zero) begin
                    if (i_stat.big) n_state = ST_MOD_PTR;
                    else if (i_stat.action == ACT_FRAME) n_state = ST_FRAME2;
                    else n_state = ST_DRAIN;
                end
            end
            ST_MOD_PTR: begin
                if (i_stat.mod_done) begin
                    n_state = (i_stat.action == ACT_FRAME) ? ST_FRAME2 : ST_DRAIN;
                end
            end
            ST_FRAME2: begin
                n_state = i_stat.seq_eq_exp ? ST_DRAIN : ST_MOD_SLOT;
            end
            ST_MOD_SLOT: begin
                if (i_stat.mod_done) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!i_stat.valid_ptr) n_state = ST_FIN;
            end
            ST_AGE: begin
                if (i_stat.valid_ptr || i_stat.cnt_one) n_state = ST_DRAIN;
            end
            ST_CLOSE: begin
                if (i_stat.cnt_zero) begin
                    n_state = (i_stat.action == ACT_OPEN) ? ST_OPEN_INIT : ST_FIN;
                end
            end
            ST_OPEN_INIT: n_state = ST_FIN;
            ST_FIN:       n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        c = '0;
        case (r_state)
            ST_IDLE: begin
                c.latch = start;
            end
            ST_DISPATCH: begin
                case (i_stat.action)
                    ACT_FRAME: begin
                        if (!i_stat.active) begin
                            c.emit_in = 1'b1;
                            c.disp    = DISP_NOSESS;
                        end else if (!i_stat.in_half) begin
                            c.emit_in = 1'b1;
                            c.disp    = i_stat.ast ? DISP_OLD : DISP_DELIVER;
                        end else begin
                            c.set_ast = 1'b1;
                            if (i_stat.beyond) begin
                                c.set_restart = i_stat.timer;
                                c.ld_slide    = 1'b1;
                                c.slide_sel   = 1'b0;
                            end
                        end
                    end
                    ACT_AGING: begin
                        c.timer_wr  = 1'b1;
                        c.timer_val = 1'b0;
                        if (i_stat.active && i_stat.occ_nz) begin
                            c.advance    = 1'b1;
                            c.ld_cnt_win = 1'b1;
                        end
                    end
                    ACT_SCROLL: begin
                        if (!i_stat.active) begin
                            c.emit_nosess = 1'b1;
                        end else if (i_stat.in_half) begin
                            c.ld_slide  = 1'b1;
                            c.slide_sel = 1'b1;
                        end
                    end
                    ACT_CLOSE: begin
                        if (!i_stat.active) begin
                            c.emit_nosess = 1'b1;
                            c.cmd_wr      = 1'b1;
                            c.cmd_val     = i_stat.timer ? TCMD_STOP : TCMD_NONE;
                            c.timer_wr    = 1'b1;
                            c.timer_val   = 1'b0;
                        end else begin
                            c.scan_init = 1'b1;
                        end
                    end
                    ACT_OPEN: begin
                        if (i_stat.active && !i_stat.same_open) c.scan_init = 1'b1;
                    end
                    default: c = '0;
                endcase
            end
            ST_SLIDE: begin
                if (i_stat.cnt_zero) begin
                    c.set_exp_tgt = 1'b1;
                    if (i_stat.big) begin
                        c.mod_start = 1'b1;
                        c.mod_sel   = 1'b1;
                    end
                end else begin
                    c.rel_ptr = i_stat.valid_ptr;
                    c.disp    = DISP_DELIVER;
                    c.advance = 1'b1;
                    c.dec_cnt = 1'b1;
                end
            end
            ST_MOD_PTR: begin
                c.set_ptr_mod = i_stat.mod_done;
            end
            ST_FRAME2: begin
                if (i_stat.seq_eq_exp) begin
                    c.set_restart = i_stat.timer;
                    c.advance     = 1'b1;
                    c.emit_in     = 1'b1;
                    c.disp        = DISP_DELIVER;
                end else begin
                    c.mod_start = 1'b1;
                    c.mod_sel   = 1'b0;
                end
            end
            ST_MOD_SLOT: begin
                if (i_stat.mod_done) begin
                    if (i_stat.valid_mod) begin
                        c.emit_in = 1'b1;
                        c.disp    = DISP_DUP;
                    end else begin
                        c.store = 1'b1;
                    end
                end
            end
            ST_DRAIN: begin
                if (i_stat.valid_ptr) begin
                    c.rel_ptr = 1'b1;
                    c.disp    = DISP_DELIVER;
                    c.advance = 1'b1;
                end else begin
                    case (i_stat.action)
                        ACT_FRAME: begin
                            if (!i_stat.timer) begin
                                if (i_stat.occ_nz) begin
                                    c.timer_wr  = 1'b1;
                                    c.timer_val = 1'b1;
                                    c.cmd_wr    = 1'b1;
                                    c.cmd_val   = TCMD_START;
                                end
                            end else if (!i_stat.occ_nz) begin
                                c.timer_wr  = 1'b1;
                                c.timer_val = 1'b0;
                                c.cmd_wr    = 1'b1;
                                c.cmd_val   = TCMD_STOP;
                            end else if (i_stat.restart) begin
                                c.cmd_wr  = 1'b1;
                                c.cmd_val = TCMD_START;
                            end
                        end
                        ACT_AGING: begin
                            c.timer_wr  = 1'b1;
                            c.timer_val = i_stat.occ_nz;
                            c.cmd_wr    = 1'b1;
                            c.cmd_val   = i_stat.occ_nz ? TCMD_START : TCMD_NONE;
                        end
                        default: c.cmd_wr = 1'b0;
                    endcase
                end
            end
            ST_AGE: begin
                // step to the next stored frame past the hole
                c.advance = 1'b1;
                if (i_stat.valid_ptr) begin
                    c.rel_ptr = 1'b1;
                    c.disp    = DISP_DELIVER;
                end else begin
                    c.dec_cnt = 1'b1;
                end
            end
            ST_CLOSE: begin
                if (i_stat.cnt_zero) begin
                    c.clr_active = 1'b1;
                    c.cmd_wr     = 1'b1;
                    c.cmd_val    = i_stat.timer ? TCMD_STOP : TCMD_NONE;
                    c.timer_wr   = 1'b1;
                    c.timer_val  = 1'b0;
                end else begin
                    c.rel_sptr  = i_stat.valid_sptr;
                    c.disp      = (i_stat.action == ACT_CLOSE && i_stat.flush) ?
                                  DISP_FLUSH : DISP_DELIVER;
                    c.scan_step = 1'b1;
                    c.dec_cnt   = 1'b1;
                end
            end
            ST_OPEN_INIT: c.open_init = 1'b1;
            ST_FIN:       c.finish    = 1'b1;
            default:      c = '0;
        endcase
    end

    assign o_cmd = c;
    assign busy  = (r_state != ST_IDLE);

endmodule

### src/bar_dp.sv
`timescale 1ns / 1ps
// Datapath: session registers, slot store, remainder unit and result staging.
// Depends on bar_pkg and bar_mod.
module bar_dp #(
    parameter int MAX_WINDOW = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bar_pkg::t_item      i_item,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [bar_pkg::CFG_W-1:0] i_cfg_wdata,
    input  bar_pkg::t_dp_cmd    i_cmd,
    output bar_pkg::t_dp_stat   o_stat,
    output logic                o_res_valid,
    output bar_pkg::t_result    o_result
);
    import bar_pkg::*;

    localparam int WinW  = $clog2(MAX_WINDOW + 1);
    localparam int SlotW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    t_item                 r_item;
    logic [WSZ_W-1:0]      r_cfg_win;
    logic [SEQ_W-1:0]      r_cfg_start;
    logic [WinW-1:0]       r_win;
    logic [SEQ_W-1:0]      r_base;
    logic [SEQ_W-1:0]      r_exp;
    logic [SlotW-1:0]      r_ptr;
    logic [SlotW-1:0]      r_sptr;
    logic                  r_ast;
    logic                  r_active;
    logic                  r_timer;
    logic                  r_restart;
    logic [WinW-1:0]       r_occ;
    logic [MAX_WINDOW-1:0] r_valid;
    logic [HANDLE_W-1:0]   r_hnd [MAX_WINDOW];
    logic [SEQ_W-1:0]      r_sq  [MAX_WINDOW];
    logic [SEQ_W-1:0]      r_tgt;
    logic [WinW-1:0]       r_cnt;
    logic                  r_big;
    t_tcmd                 r_cmd;
    t_result               r_pend;
    logic                  r_pend_v;
    t_result               r_out;
    logic                  r_out_v;

    logic [WinW-1:0]   w_cfg_clamp;
    logic [SEQ_W-1:0]  w_win12;
    logic [SEQ_W-1:0]  w_fr_tgt;
    logic [SEQ_W-1:0]  w_tgt;
    logic [SEQ_W-1:0]  w_gap;
    logic              w_big;
    logic [WinW-1:0]   w_cnt;
    logic [WinW-1:0]   w_ptr_p1;
    logic [WinW-1:0]   w_sptr_p1;
    logic              w_off_top;
    logic [SlotW-1:0]  w_ptr_next;
    logic [SlotW-1:0]  w_sptr_next;
    logic [SlotW-1:0]  w_rel_addr;
    logic              w_rel;
    logic              w_new_v;
    t_result           w_new;
    t_result           w_fin;
    logic              w_mod_done;
    logic [SlotW-1:0]  w_mod_rem;
    logic [SEQ_W-1:0]  w_mod_dvd;

    always_comb begin
        if (r_cfg_win == '0) w_cfg_clamp = WinW'(1);
        else if (r_cfg_win > WSZ_W'(MAX_WINDOW)) w_cfg_clamp = WinW'(MAX_WINDOW);
        else w_cfg_clamp = r_cfg_win[WinW-1:0];
        w_win12     = SEQ_W'(r_win);
        w_fr_tgt    = r_item.seq - w_win12 + SEQ_W'(1);
        w_tgt       = i_cmd.slide_sel ? r_item.seq : w_fr_tgt;
        w_gap       = w_tgt - r_exp;
        w_big       = w_gap > w_win12;
        w_cnt       = w_big ? r_win : w_gap[WinW-1:0];
        w_ptr_p1    = WinW'(r_ptr) + WinW'(1);
        w_sptr_p1   = WinW'(r_sptr) + WinW'(1);
        // offset from the base wraps to zero, and so does the slot
        w_off_top   = ((r_exp - r_base) == SEQ_MASK);
        w_ptr_next  = (w_ptr_p1 == r_win || w_off_top) ? '0 : SlotW'(w_ptr_p1);
        w_sptr_next = (w_sptr_p1 == r_win) ? '0 : SlotW'(w_sptr_p1);
        w_rel_addr  = i_cmd.rel_sptr ? r_sptr : r_ptr;
        w_rel       = i_cmd.rel_ptr | i_cmd.rel_sptr;
        w_mod_dvd   = (i_cmd.mod_sel ? r_tgt : r_item.seq) - r_base;
    end

    always_comb begin
        w_new   = '0;
        w_new_v = i_cmd.emit_in | i_cmd.emit_nosess | w_rel;
        if (i_cmd.emit_in) begin
            w_new.out_handle  = r_item.handle;
            w_new.out_seq     = r_item.seq;
            w_new.disposition = i_cmd.disp;
        end else if (i_cmd.emit_nosess) begin
            w_new.disposition = DISP_NOSESS;
        end else if (w_rel) begin
            w_new.out_handle  = r_hnd[w_rel_addr];
            w_new.out_seq     = r_sq[w_rel_addr];
            w_new.disposition = i_cmd.disp;
        end
        w_fin           = r_pend_v ? r_pend : '0;
        w_fin.last      = 1'b1;
        w_fin.timer_cmd = r_cmd;
    end

    bar_mod #(
        .WIN_W  (WinW),
        .SLOT_W (SlotW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.mod_start),
        .i_dividend (w_mod_dvd),
        .i_divisor  (r_win),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_win   <= WSZ_W'(32);
            r_cfg_start <= '0;
            r_win       <= (MAX_WINDOW < 32) ? WinW'(MAX_WINDOW) : WinW'(32);
            r_base      <= '0;
            r_exp       <= '0;
            r_ptr       <= '0;
            r_sptr      <= '0;
            r_ast       <= 1'b0;
            r_active    <= 1'b0;
            r_timer     <= 1'b0;
            r_restart   <= 1'b0;
            r_occ       <= '0;
            r_valid     <= '0;
            r_cnt       <= '0;
            r_big       <= 1'b0;
            r_cmd       <= TCMD_NONE;
            r_pend_v    <= 1'b0;
            r_out_v     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IDX_WINDOW: r_cfg_win   <= i_cfg_wdata[WSZ_W-1:0];
                    CFG_IDX_START:  r_cfg_start <= i_cfg_wdata[SEQ_W-1:0];
                    default:        r_cfg_start <= r_cfg_start;
                endcase
            end
            if (i_cmd.latch) begin
                r_restart <= 1'b0;
                r_cmd     <= TCMD_NONE;
            end
            if (i_cmd.set_ast)     r_ast     <= 1'b1;
            if (i_cmd.set_restart) r_restart <= 1'b1;
            if (i_cmd.ld_slide) begin
                r_cnt <= w_cnt;
                r_big <= w_big;
            end
            if (i_cmd.ld_cnt_win || i_cmd.scan_init) r_cnt <= r_win;
            if (i_cmd.dec_cnt)   r_cnt  <= r_cnt - WinW'(1);
            if (i_cmd.scan_init) r_sptr <= r_ptr;
            if (i_cmd.scan_step) r_sptr <= w_sptr_next;
            if (i_cmd.advance) begin
                r_exp <= r_exp + SEQ_W'(1);
                r_ptr <= w_ptr_next;
            end
            if (i_cmd.set_exp_tgt) r_exp <= r_tgt;
            if (i_cmd.set_ptr_mod) r_ptr <= w_mod_rem;
            if (w_rel) begin
                r_valid[w_rel_addr] <= 1'b0;
                r_occ               <= r_occ - WinW'(1);
            end
            if (i_cmd.store) begin
                r_valid[w_mod_rem] <= 1'b1;
                r_occ              <= r_occ + WinW'(1);
            end
            if (i_cmd.clr_active) r_active <= 1'b0;
            if (i_cmd.timer_wr)   r_timer  <= i_cmd.timer_val;
            if (i_cmd.cmd_wr)     r_cmd    <= i_cmd.cmd_val;
            if (i_cmd.open_init) begin
                r_win    <= w_cfg_clamp;
                r_base   <= r_cfg_start;
                r_exp    <= r_cfg_start;
                r_ptr    <= '0;
                r_ast    <= 1'b0;
                r_active <= 1'b1;
                r_timer  <= 1'b0;
                r_occ    <= '0;
                r_valid  <= '0;
            end
            // hold one beat back so the final one can carry last and the timer command
            r_out_v <= i_cmd.finish | (w_new_v & r_pend_v);
            if (i_cmd.finish) begin
                r_pend_v <= 1'b0;
            end else if (w_new_v) begin
                r_pend_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch)    r_item <= i_item;
        if (i_cmd.ld_slide) r_tgt  <= w_tgt;
        if (i_cmd.store) begin
            r_hnd[w_mod_rem] <= r_item.handle;
            r_sq[w_mod_rem]  <= r_item.seq;
        end
        if (i_cmd.finish) begin
            r_out <= w_fin;
        end else if (w_new_v) begin
            r_pend <= w_new;
            r_out  <= r_pend;
        end
    end

    always_comb begin
        o_stat            = '0;
        o_stat.action     = r_item.action;
        o_stat.flush      = r_item.flush_mode;
        o_stat.active     = r_active;
        o_stat.in_half    = (r_item.seq - r_exp) <= HALF_SPACE;
        o_stat.beyond     = (r_item.seq - r_exp - w_win12) <= HALF_SPACE;
        o_stat.big        = r_big;
        o_stat.cnt_zero   = (r_cnt == '0);
        o_stat.cnt_one    = (r_cnt == WinW'(1));
        o_stat.valid_ptr  = r_valid[r_ptr];
        o_stat.valid_sptr = r_valid[r_sptr];
        o_stat.valid_mod  = r_valid[w_mod_rem];
        o_stat.mod_done   = w_mod_done;
        o_stat.seq_eq_exp = (r_item.seq == r_exp);
        o_stat.same_open  = (r_win == w_cfg_clamp) && (r_exp == r_cfg_start);
        o_stat.timer      = r_timer;
        o_stat.restart    = r_restart;
        o_stat.occ_nz     = (r_occ != '0);
        o_stat.ast        = r_ast;
    end

    assign o_res_valid = r_out_v;
    assign o_result    = r_out;

    a_occ_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_occ))
        else $error("occupancy count disagrees with slot valid bits");

    a_ptr_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (WinW'(r_ptr) < r_win))
        else $error("expected-slot pointer outside window");

    a_last_clears_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.last) |-> !r_pend_v)
        else $error("final beat sent with a result still held back");

endmodule

### src/block_ack_reorder_buffer.sv
`timescale 1ns / 1ps
// Top level of the block-ack receive reorder buffer: controller plus datapath.
// Depends on bar_pkg, bar_ctrl, bar_dp (and bar_mod below it).
//
// One item is taken when start is high and busy is low; busy stays high until
// its final result has been staged. The sequencer visits one slot per cycle
// when it slides, drains, ages or closes the window, and each slot index
// computed from an arbitrary sequence number goes through the bit-serial
// remainder unit. Results leave one per cycle on o_res_valid and cannot be
// held off; the last beat of each item has last set and carries the timer
// command. Slot valid bits clear at once on reset and on open.
module block_ack_reorder_buffer #(
    parameter int MAX_WINDOW = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  bar_pkg::t_item            i_item,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [bar_pkg::CFG_W-1:0] i_cfg_wdata,
    output logic                      o_res_valid,
    output bar_pkg::t_result          o_result
);
    import bar_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    bar_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    bar_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_res_valid (o_res_valid),
        .o_result    (o_result)
    );

endmodule
